FILE: sv/saq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// saq_pkg: shared types and constants of the sorted alarm queue
// Entry layout, result kinds, input modes and ring index helper.
// ----------------------------------------------------------------------------
package saq_pkg;

	localparam int unsigned QUEUE_DEPTH  = 16;
	localparam int unsigned RESULT_LIMIT = 16;
	localparam int unsigned IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned POP_W        = $clog2(RESULT_LIMIT + 1);

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_EXPIRE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [7:0]  tag;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tag;
		logic [31:0] deadline;
	} result_t;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CNT_W:0]   sum_t;

	// ring slot at offset off from base; off stays below QUEUE_DEPTH
	function automatic idx_t wrap_idx(idx_t base, cnt_t off);
		sum_t s;
		s = sum_t'(base) + sum_t'(off);
		if (s >= sum_t'(QUEUE_DEPTH)) begin
			s = s - sum_t'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/saq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// saq_store: alarm entry memory
// Ring storage of deadline and tag, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module saq_store (
	input  wire             clk,
	input  wire             we,
	input  saq_pkg::idx_t   waddr,
	input  saq_pkg::entry_t wdata,
	input  saq_pkg::idx_t   raddr,
	output saq_pkg::entry_t rdata
);

	saq_pkg::entry_t mem [saq_pkg::QUEUE_DEPTH];
	saq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: sv/saq_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// saq_cmp: wrap-aware deadline compare
// Tells whether deadline a is at or before b modulo 2^32.
// ----------------------------------------------------------------------------
module saq_cmp (
	input  wire [31:0] a,
	input  wire [31:0] b,
	output logic       not_later
);

	logic [31:0] diff;

	assign diff      = b - a;
	assign not_later = ~diff[31];

endmodule
`default_nettype wire

FILE: sv/sorted_alarm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_alarm_queue: deadline-sorted alarm queue
// Insert: read and compare states per entry moved toward the tail, then put and finish;
// an empty queue goes straight to put, a full one straight to finish with a reject.
// Tick: read and compare states per entry popped, up to RESULT_LIMIT; one compare unit.
// Throughput: one request at a time; a new request is taken once results are queued.
// Memory reads are registered, so each compare step has a read state and a compare state.
// Reset clears the seconds counter and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_alarm_queue (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // delay_seconds[15:0], alarm_tag[23:16]
	input  wire  [0:0]  s_axis_tuser,   // mode[0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // tag[7:0], deadline[39:8]
	output logic [1:0]  m_axis_tuser,   // kind[1:0]
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_TK_RD,
		ST_TK_CMP,
		ST_FIN
	} state_t;

	state_t                   state_q;
	logic [31:0]              now_q;
	saq_pkg::idx_t            head_q;
	saq_pkg::cnt_t            count_q;
	saq_pkg::cnt_t            pos_q;
	logic [saq_pkg::POP_W-1:0] pops_q;
	logic [31:0]              dl_q;
	logic [7:0]               tag_q;
	saq_pkg::result_t         pend_q;
	logic                     pend_valid_q;
	saq_pkg::result_t         out_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	logic             accept;
	logic             out_free;
	logic             out_load;
	logic [31:0]      new_dl;
	saq_pkg::idx_t    rd_addr;
	saq_pkg::idx_t    wr_addr;
	saq_pkg::entry_t  wr_data;
	saq_pkg::entry_t  rd_data;
	logic             wr_en;
	logic [31:0]      cmp_b;
	logic             not_later;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = pend_valid_q && out_free &&
		(((state_q == ST_TK_CMP) && not_later) || (state_q == ST_FIN));
	assign new_dl        = now_q + {16'd0, s_axis_tdata[15:0]};

	always_comb begin
		unique case (state_q)
			ST_INS_RD: rd_addr = saq_pkg::wrap_idx(head_q, pos_q - 1'b1);
			default:   rd_addr = head_q;
		endcase
	end

	assign cmp_b   = (state_q == ST_TK_CMP) ? now_q : dl_q;
	assign wr_addr = saq_pkg::wrap_idx(head_q, pos_q);
	assign wr_en   = ((state_q == ST_INS_CMP) && !not_later) || (state_q == ST_INS_PUT);

	always_comb begin
		if (state_q == ST_INS_PUT) begin
			wr_data.deadline = dl_q;
			wr_data.tag      = tag_q;
		end else begin
			wr_data = rd_data;
		end
	end

	saq_store u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	saq_cmp u_cmp (
		.a         (rd_data.deadline),
		.b         (cmp_b),
		.not_later (not_later)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			head_q       <= '0;
			count_q      <= '0;
			pos_q        <= '0;
			pops_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser[0] == saq_pkg::MODE_INSERT) begin
							dl_q  <= new_dl;
							tag_q <= s_axis_tdata[23:16];
							pos_q <= count_q;
							if (count_q == saq_pkg::cnt_t'(saq_pkg::QUEUE_DEPTH)) begin
								pend_q.kind     <= saq_pkg::KIND_REJECT;
								pend_q.tag      <= s_axis_tdata[23:16];
								pend_q.deadline <= new_dl;
								pend_valid_q    <= 1'b1;
								state_q         <= ST_FIN;
							end else if (count_q == '0) begin
								state_q <= ST_INS_PUT;
							end else begin
								state_q <= ST_INS_RD;
							end
						end else begin
							now_q   <= now_q + 32'd1;
							pops_q  <= '0;
							state_q <= ST_TK_RD;
						end
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS_CMP;
				end
				ST_INS_CMP: begin
					if (!not_later) begin
						pos_q   <= pos_q - 1'b1;
						state_q <= (pos_q == saq_pkg::cnt_t'(1)) ? ST_INS_PUT : ST_INS_RD;
					end else begin
						state_q <= ST_INS_PUT;
					end
				end
				ST_INS_PUT: begin
					count_q         <= count_q + 1'b1;
					pend_q.kind     <= saq_pkg::KIND_ACCEPT;
					pend_q.tag      <= tag_q;
					pend_q.deadline <= dl_q;
					pend_valid_q    <= 1'b1;
					state_q         <= ST_FIN;
				end
				ST_TK_RD: begin
					if (count_q == '0 ||
						pops_q == saq_pkg::POP_W'(saq_pkg::RESULT_LIMIT)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_TK_CMP;
					end
				end
				ST_TK_CMP: begin
					if (!not_later) begin
						state_q <= ST_FIN;
					end else if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_q      <= pend_q;
							out_last_q <= 1'b0;
						end
						pend_q.kind     <= saq_pkg::KIND_EXPIRE;
						pend_q.tag      <= rd_data.tag;
						pend_q.deadline <= rd_data.deadline;
						pend_valid_q    <= 1'b1;
						head_q          <= saq_pkg::wrap_idx(head_q, saq_pkg::cnt_t'(1));
						count_q         <= count_q - 1'b1;
						pops_q          <= pops_q + 1'b1;
						state_q         <= ST_TK_RD;
					end
				end
				ST_FIN: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q        <= pend_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.deadline, out_q.tag};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
